>>> hw/rtl/owi_pkg.sv
package owi_pkg;

  localparam logic [31:0] RATE_SCALE   = 32'd2867080570;
  localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
  localparam logic [46:0] TINY_TURN    = 47'd684;
  localparam logic [23:0] DPT_RESET    = 24'd160757;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS    = 62;

  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2F9;
      5'd15: v = 30'h0000517C;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A2F;
      5'd19: v = 30'h00000517;
      5'd20: v = 30'h0000028B;
      5'd21: v = 30'h00000145;
      5'd22: v = 30'h000000A2;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000028;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000002;
      5'd29: v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/owi_cordic.sv
module owi_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [33:0] sin_q,
  output logic signed [33:0] cos_q
);
  import owi_pkg::*;

  localparam logic signed [33:0] QUARTER = 34'sd1073741824;
  localparam logic signed [33:0] HALF    = 34'sd2147483648;
  localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

  logic              busy;
  logic [4:0]        it;
  logic              flip;
  logic signed [33:0] x, y, z;
  logic signed [33:0] x_next, y_next, z_next, z0, dx, dy, at;

  assign z0 = {{2{angle[31]}}, angle};
  assign dx = y >>> it;
  assign dy = x >>> it;
  assign at = {4'b0, atan_entry(it)};

  always_comb begin
    if (!z[33]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - at;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      it   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        it   <= '0;
        x    <= CORDIC_GAIN;
        y    <= '0;
        // fold the back half-plane onto the front one
        if (z0 > QUARTER || z0 < -QUARTER) begin
          z    <= z0[33] ? z0 + HALF : z0 - HALF;
          flip <= 1'b1;
        end else begin
          z    <= z0;
          flip <= 1'b0;
        end
      end else if (busy) begin
        x  <= x_next;
        y  <= y_next;
        z  <= z_next;
        it <= it + 5'd1;
        if (it == LAST) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          sin_q <= flip ? -y_next : y_next;
          cos_q <= flip ? -x_next : x_next;
        end
      end
    end
  end

  cordic_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("cordic restarted while busy");
  cordic_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("cordic done held");
  cordic_done_end: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("cordic done without run");

endmodule

>>> hw/rtl/owi_div.sv
module owi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [61:0] num,
  input  logic [45:0] den,
  output logic        done,
  output logic [31:0] quot
);
  import owi_pkg::*;

  localparam logic [5:0] LAST = 6'(DIV_STEPS - 1);

  logic        busy;
  logic [5:0]  cnt;
  logic [61:0] nsh;
  logic [45:0] rem;
  logic [45:0] dv;
  logic [46:0] t;
  logic        ge;

  assign t  = {rem, nsh[61]};
  assign ge = t >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        nsh  <= num;
        rem  <= '0;
        dv   <= den;
        quot <= '0;
      end else if (busy) begin
        rem  <= ge ? 46'(t - {1'b0, dv}) : t[45:0];
        nsh  <= {nsh[60:0], 1'b0};
        quot <= {quot[30:0], ge};
        cnt  <= cnt + 6'd1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  div_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  div_nonzero: assert property (@(posedge clk) disable iff (rst) start |-> den != '0)
    else $error("divide by zero");
  div_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");

endmodule

>>> hw/rtl/wheel_imu_odometry_integrator.sv
// Dead-reckoning pose integrator for wheel ticks plus gyro yaw rate.
// Input stream (s_*): one word per event. tuser = 0 is a wheel event
// (time stamp, signed ticks), tuser = 1 latches a new yaw rate.
// Output stream (m_*): one pose word per wheel event, except the first
// wheel event after reset, which only records its stamp.
// Config channel (cfg_*): distance per tick, always ready; write it only
// while no event is in flight.
// Sequence: rate updates and the first wheel word are taken in S_IDLE. A
// wheel word runs two 30-step CORDIC passes and a 62-step restoring
// divide, plus products on the one shared 32x32 multiplier. When the
// turn is tiny the first CORDIC pass and the divide are skipped.
// s_tready is high only between words.
// The pose goes into an output register; the next word is accepted while
// it waits, and a following pose is held in the sequencer until m_tready.
// Reset (rst, synchronous) clears pose, heading, rate and stamp history
// and loads the default distance per tick.
module wheel_imu_odometry_integrator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,  // stamp_us[31:0], delta_ticks[47:32], rate_in[67:48]
  input  logic [0:0]   s_tuser,  // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,  // pos_x[31:0], pos_y[63:32], heading[79:64], pose_stamp[111:80]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data  // distance_per_tick
);
  import owi_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M1   = 5'd1;
  localparam logic [4:0] S_M2   = 5'd2;
  localparam logic [4:0] S_M3   = 5'd3;
  localparam logic [4:0] S_M4   = 5'd4;
  localparam logic [4:0] S_M5   = 5'd5;
  localparam logic [4:0] S_C1   = 5'd6;
  localparam logic [4:0] S_N    = 5'd7;
  localparam logic [4:0] S_DS   = 5'd8;
  localparam logic [4:0] S_DW   = 5'd9;
  localparam logic [4:0] S_MID  = 5'd10;
  localparam logic [4:0] S_MW   = 5'd11;
  localparam logic [4:0] S_G1   = 5'd12;
  localparam logic [4:0] S_G2   = 5'd13;
  localparam logic [4:0] S_G3   = 5'd14;
  localparam logic [4:0] S_X1   = 5'd15;
  localparam logic [4:0] S_X2   = 5'd16;
  localparam logic [4:0] S_X3   = 5'd17;
  localparam logic [4:0] S_Y2   = 5'd18;
  localparam logic [4:0] S_Y3   = 5'd19;
  localparam logic [4:0] S_DONE = 5'd20;

  logic [4:0]  state;
  logic        have_stamp;
  logic [31:0] last_stamp;
  logic signed [19:0] yaw_rate;
  logic [47:0] x_acc, y_acc;
  logic [31:0] yaw_acc;
  logic [23:0] dpt;

  logic [31:0] dt, stamp;
  logic signed [15:0] ticks;
  logic [31:0] mlo;
  logic [51:0] phi;
  logic [46:0] wtmag;
  logic [39:0] ut_mag;
  logic [31:0] sh_mag;
  logic        sh_neg;
  logic [31:0] f_mag;
  logic        f_neg;
  logic [31:0] sm_mag, cm_mag;
  logic        sm_neg, cm_neg;
  logic [42:0] g_mag;
  logic        g_neg;
  logic [63:0] pa;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic        wneg;
  logic [19:0] rate_mag;
  logic [15:0] tick_mag;
  logic [45:0] h;
  logic [31:0] mid, wt32;
  logic [63:0] q_sum;
  logic [47:0] q_signed;
  logic [52:0] wt_sum;

  logic        cor_start, cor_done;
  logic [31:0] cor_angle;
  logic signed [33:0] cor_sin, cor_cos;
  logic        div_start, div_done;
  logic [31:0] div_quot;

  logic        accept, out_free;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign wneg     = yaw_rate[19];
  assign rate_mag = wneg ? 20'(-yaw_rate) : 20'(yaw_rate);
  assign tick_mag = ticks[15] ? 16'(-ticks) : 16'(ticks);
  assign h        = wtmag[46:1];
  assign mid      = wneg ? yaw_acc - h[31:0] : yaw_acc + h[31:0];
  assign wt32     = wneg ? 32'(-wtmag[31:0]) : wtmag[31:0];
  assign wt_sum   = {1'b0, phi} + {21'b0, prod[63:32]};

  // (a*b + 2^29) >> 30 with a split at bit 30; pa holds the high partial
  assign q_sum    = pa + ((prod + 64'd536870912) >> 30);
  assign q_signed = g_neg ^ ((state == S_X3) ? cm_neg : sm_neg) ?
                    48'(-q_sum[47:0]) : q_sum[47:0];

  assign cor_start = (state == S_MID) || (state == S_M5 && wtmag >= TINY_TURN);
  assign cor_angle = (state == S_MID) ? mid : h[31:0];
  assign div_start = (state == S_DS);

  always_comb begin
    case (state)
      S_M1: begin
        mul_a = {12'b0, rate_mag};
        mul_b = dt;
      end
      S_M2: begin
        mul_a = {12'b0, prod[51:32]};
        mul_b = RATE_SCALE;
      end
      S_M3: begin
        mul_a = mlo;
        mul_b = RATE_SCALE;
      end
      S_M4: begin
        mul_a = {16'b0, tick_mag};
        mul_b = {8'b0, dpt};
      end
      S_N: begin
        mul_a = sh_mag;
        mul_b = {2'b0, TURN_PER_RAD};
      end
      S_G1: begin
        mul_a = {22'b0, ut_mag[39:30]};
        mul_b = f_mag;
      end
      S_G2: begin
        mul_a = {2'b0, ut_mag[29:0]};
        mul_b = f_mag;
      end
      S_X1: begin
        mul_a = {19'b0, g_mag[42:30]};
        mul_b = cm_mag;
      end
      S_X2: begin
        mul_a = {2'b0, g_mag[29:0]};
        mul_b = cm_mag;
      end
      S_X3: begin
        mul_a = {19'b0, g_mag[42:30]};
        mul_b = sm_mag;
      end
      S_Y2: begin
        mul_a = {2'b0, g_mag[29:0]};
        mul_b = sm_mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  owi_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .sin_q (cor_sin),
    .cos_q (cor_cos)
  );

  owi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod[61:0]),
    .den   (h),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      have_stamp <= 1'b0;
      last_stamp <= '0;
      yaw_rate   <= '0;
      x_acc      <= '0;
      y_acc      <= '0;
      yaw_acc    <= '0;
      dpt        <= DPT_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dpt <= cfg_data;
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser[0]) begin
              yaw_rate <= s_tdata[67:48];
            end else if (!have_stamp) begin
              have_stamp <= 1'b1;
              last_stamp <= s_tdata[31:0];
            end else begin
              dt         <= s_tdata[31:0] - last_stamp;
              last_stamp <= s_tdata[31:0];
              stamp      <= s_tdata[31:0];
              ticks      <= s_tdata[47:32];
              state      <= S_M1;
            end
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          mlo   <= prod[31:0];
          state <= S_M3;
        end
        S_M3: begin
          phi   <= prod[51:0];
          state <= S_M4;
        end
        S_M4: begin
          wtmag <= wt_sum[52:6];
          state <= S_M5;
        end
        S_M5: begin
          ut_mag <= prod[39:0];
          if (wtmag < TINY_TURN) begin
            f_mag <= 32'h4000_0000;
            f_neg <= 1'b0;
            state <= S_MID;
          end else begin
            state <= S_C1;
          end
        end
        S_C1: begin
          if (cor_done) begin
            sh_neg <= cor_sin[33];
            sh_mag <= cor_sin[33] ? 32'(-cor_sin) : cor_sin[31:0];
            state  <= S_N;
          end
        end
        S_N:  state <= S_DS;
        S_DS: state <= S_DW;
        S_DW: begin
          if (div_done) begin
            f_mag <= div_quot;
            f_neg <= sh_neg;
            state <= S_MID;
          end
        end
        S_MID: state <= S_MW;
        S_MW: begin
          if (cor_done) begin
            sm_neg <= cor_sin[33];
            sm_mag <= cor_sin[33] ? 32'(-cor_sin) : cor_sin[31:0];
            cm_neg <= cor_cos[33];
            cm_mag <= cor_cos[33] ? 32'(-cor_cos) : cor_cos[31:0];
            state  <= S_G1;
          end
        end
        S_G1: state <= S_G2;
        S_G2: begin
          pa    <= prod;
          state <= S_G3;
        end
        S_G3: begin
          g_mag <= q_sum[42:0];
          g_neg <= ticks[15] ^ f_neg;
          state <= S_X1;
        end
        S_X1: state <= S_X2;
        S_X2: begin
          pa    <= prod;
          state <= S_X3;
        end
        S_X3: begin
          x_acc <= x_acc + q_signed;
          state <= S_Y2;
        end
        S_Y2: begin
          pa    <= prod;
          state <= S_Y3;
        end
        S_Y3: begin
          y_acc   <= y_acc + q_signed;
          yaw_acc <= yaw_acc + wt32;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {stamp, yaw_acc[31:16], y_acc[47:16], x_acc[47:16]};
    end
  end

  pose_from_done: assert property (@(posedge clk) disable iff (rst)
      $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("pose word without finished event");
  tiny_skips: assert property (@(posedge clk) disable iff (rst)
      (state == S_M5 && wtmag < TINY_TURN) |=> state == S_MID)
    else $error("tiny turn took the divide path");
  wheel_starts: assert property (@(posedge clk) disable iff (rst)
      (accept && !s_tuser[0] && have_stamp) |=> state == S_M1)
    else $error("wheel word did not start the sequence");
  done_no_drop: assert property (@(posedge clk) disable iff (rst)
      (state == S_DONE && m_tvalid && !m_tready) |=> state == S_DONE)
    else $error("pose left while output stalled");

endmodule
